// ----- rtl/tet_grid_cell_decomposer_top_defines.svh -----
// Assertion macros for the tet grid cell decomposer checker.
// Depends on nothing; included by the files that hold assertions.
`ifndef TET_GRID_CELL_DECOMPOSER_TOP_DEFINES_SVH
`define TET_GRID_CELL_DECOMPOSER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TGCD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tgcd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TGCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tgcd assertion failed");

`endif

// ----- rtl/tgcd_pkg.sv -----
// Types, register indexes and tetrahedron pattern tables for the decomposer.
// No dependencies; imported by every module of the block.
package tgcd_pkg;

  localparam int CELLS_W  = 10;
  localparam int LAT_W    = 11;
  localparam int VTX_W    = 30;
  localparam int TET_W    = 33;
  localparam int SLOT_W   = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [CELLS_W-1:0] CELLS_FIELD_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_CELLS_X     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Z     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPLIT_STYLE = 2'd3;

  localparam logic [SLOT_W-1:0] LAST_SLOT_FIVE = 3'd4;
  localparam logic [SLOT_W-1:0] LAST_SLOT_SIX  = 3'd5;

  typedef struct packed {
    logic [CELLS_W-1:0] cell_i;
    logic [CELLS_W-1:0] cell_j;
    logic [CELLS_W-1:0] cell_k;
  } tgcd_in_t;

  typedef struct packed {
    logic [TET_W-1:0] tet_index;
    logic [VTX_W-1:0] corner_a;
    logic [VTX_W-1:0] corner_b;
    logic [VTX_W-1:0] corner_c;
    logic [VTX_W-1:0] corner_d;
    logic             cell_error;
    logic             last_tet;
  } tgcd_out_t;

  // Clamped grid size and split style seen by the pipeline.
  typedef struct packed {
    logic [CELLS_W-1:0] nx;
    logic [CELLS_W-1:0] ny;
    logic [CELLS_W-1:0] nz;
    logic               six;
  } tgcd_cfg_t;

  // One decoded cell: eight lattice corner indices and its first tet index.
  typedef struct packed {
    logic                  err;
    logic                  six;
    logic                  odd;
    logic [TET_W-1:0]      base;
    logic [7:0][VTX_W-1:0] vtx;
  } tgcd_cell_t;

  typedef logic [2:0] corner_t;
  typedef corner_t [0:3] tet_corners_t;

  localparam tet_corners_t FIVE_EVEN_TETS [0:4] = '{
    '{3'd4, 3'd6, 3'd1, 3'd3}, '{3'd6, 3'd3, 3'd4, 3'd7}, '{3'd1, 3'd3, 3'd0, 3'd4},
    '{3'd3, 3'd1, 3'd2, 3'd6}, '{3'd4, 3'd1, 3'd6, 3'd5}};
  localparam tet_corners_t FIVE_ODD_TETS [0:4] = '{
    '{3'd7, 3'd0, 3'd2, 3'd5}, '{3'd2, 3'd3, 3'd0, 3'd7}, '{3'd5, 3'd7, 3'd0, 3'd4},
    '{3'd7, 3'd2, 3'd6, 3'd5}, '{3'd0, 3'd1, 3'd2, 3'd5}};
  localparam tet_corners_t SIX_TETS [0:5] = '{
    '{3'd0, 3'd4, 3'd6, 3'd7}, '{3'd6, 3'd0, 3'd5, 3'd4}, '{3'd1, 3'd0, 3'd5, 3'd6},
    '{3'd1, 3'd2, 3'd0, 3'd6}, '{3'd0, 3'd6, 3'd2, 3'd3}, '{3'd6, 3'd3, 3'd0, 3'd7}};

  function automatic tet_corners_t tet_pattern(logic six, logic odd, logic [SLOT_W-1:0] slot);
    tet_corners_t pat;
    pat = SIX_TETS[0];
    if (six) begin
      if (slot <= LAST_SLOT_SIX) pat = SIX_TETS[slot];
    end else if (slot <= LAST_SLOT_FIVE) begin
      pat = odd ? FIVE_ODD_TETS[slot] : FIVE_EVEN_TETS[slot];
    end
    return pat;
  endfunction

endpackage

// ----- rtl/tgcd_index_pipe.sv -----
// Five-stage index pipeline: range check, lattice and cell index products,
// eight corner indices and the first tet index of each cell. Uses tgcd_pkg.
module tgcd_index_pipe (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tgcd_pkg::tgcd_cfg_t    cfg,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  tgcd_pkg::tgcd_in_t     in_data,
  output logic                   cell_valid,
  input  logic                   cell_stall,
  output tgcd_pkg::tgcd_cell_t   cell_data
);
  import tgcd_pkg::*;

  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r;
  logic adv1, adv2, adv3, adv4, adv5;

  // stage 1
  logic [CELLS_W-1:0] s1_ci_r, s1_cj_r, s1_ck_r, s1_ny_r, s1_nz_r;
  logic [LAT_W-1:0]   s1_py_r, s1_pz_r;
  logic               s1_six_r, s1_odd_r, s1_err_r;
  // stage 2
  logic [20:0]        s2_a_r;
  logic [19:0]        s2_b_r;
  logic [21:0]        s2_pp_r;
  logic [CELLS_W-1:0] s2_cj_r, s2_ck_r, s2_nz_r;
  logic [LAT_W-1:0]   s2_pz_r;
  logic               s2_six_r, s2_odd_r, s2_err_r;
  // stage 3
  logic [VTX_W-1:0]   s3_a_r, s3_b_r;
  logic [CELLS_W-1:0] s3_ck_r;
  logic [LAT_W-1:0]   s3_pz_r;
  logic [21:0]        s3_pp_r;
  logic               s3_six_r, s3_odd_r, s3_err_r;
  // stage 4
  logic [VTX_W-1:0]   s4_v0_r, s4_cell_r;
  logic [21:0]        s4_pp_r, s4_ppz_r;
  logic [LAT_W-1:0]   s4_pz_r;
  logic               s4_six_r, s4_odd_r, s4_err_r;
  // stage 5
  tgcd_cell_t         s5_r;

  logic [20:0] a1_sum;
  logic [19:0] b1_sum;
  logic [TET_W-1:0] cell_ext;
  logic [VTX_W-1:0] vtx_nxt [8];

  assign adv5 = !s5_v_r || !cell_stall;
  assign adv4 = !s4_v_r || adv5;
  assign adv3 = !s3_v_r || adv4;
  assign adv2 = !s2_v_r || adv3;
  assign adv1 = !s1_v_r || adv2;
  assign in_stall = !rst_n || !adv1;

  assign cell_valid = s5_v_r;
  assign cell_data  = s5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else begin
      if (adv1) s1_v_r <= in_valid;
      if (adv2) s2_v_r <= s1_v_r;
      if (adv3) s3_v_r <= s2_v_r;
      if (adv4) s4_v_r <= s3_v_r;
      if (adv5) s5_v_r <= s4_v_r;
    end
  end

  always_comb begin
    a1_sum   = s2_a_r + 21'(s2_cj_r);
    b1_sum   = s2_b_r + 20'(s2_cj_r);
    cell_ext = TET_W'(s4_cell_r);
    for (int c = 0; c < 8; c++) begin
      logic [21:0] off;
      unique case ({c[0] ^ c[1], c[1]})
        2'b00:   off = '0;
        2'b10:   off = s4_pp_r;
        2'b01:   off = 22'(s4_pz_r);
        default: off = s4_ppz_r;
      endcase
      vtx_nxt[c] = s4_v0_r + VTX_W'(off) + VTX_W'(c[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_ci_r  <= in_data.cell_i;
      s1_cj_r  <= in_data.cell_j;
      s1_ck_r  <= in_data.cell_k;
      s1_ny_r  <= cfg.ny;
      s1_nz_r  <= cfg.nz;
      s1_py_r  <= LAT_W'(cfg.ny) + LAT_W'(1);
      s1_pz_r  <= LAT_W'(cfg.nz) + LAT_W'(1);
      s1_six_r <= cfg.six;
      s1_odd_r <= in_data.cell_i[0] ^ in_data.cell_j[0] ^ in_data.cell_k[0];
      s1_err_r <= (in_data.cell_i >= cfg.nx) || (in_data.cell_j >= cfg.ny) ||
                  (in_data.cell_k >= cfg.nz);
    end
    if (adv2) begin
      s2_a_r   <= 21'(s1_ci_r * s1_py_r);
      s2_b_r   <= 20'(s1_ci_r * s1_ny_r);
      s2_pp_r  <= 22'(s1_py_r * s1_pz_r);
      s2_cj_r  <= s1_cj_r;
      s2_ck_r  <= s1_ck_r;
      s2_nz_r  <= s1_nz_r;
      s2_pz_r  <= s1_pz_r;
      s2_six_r <= s1_six_r;
      s2_odd_r <= s1_odd_r;
      s2_err_r <= s1_err_r;
    end
    if (adv3) begin
      s3_a_r   <= VTX_W'(a1_sum * s2_pz_r);
      s3_b_r   <= VTX_W'(b1_sum * s2_nz_r);
      s3_ck_r  <= s2_ck_r;
      s3_pz_r  <= s2_pz_r;
      s3_pp_r  <= s2_pp_r;
      s3_six_r <= s2_six_r;
      s3_odd_r <= s2_odd_r;
      s3_err_r <= s2_err_r;
    end
    if (adv4) begin
      s4_v0_r   <= s3_a_r + VTX_W'(s3_ck_r);
      s4_cell_r <= s3_b_r + VTX_W'(s3_ck_r);
      s4_pp_r   <= s3_pp_r;
      s4_ppz_r  <= s3_pp_r + 22'(s3_pz_r);
      s4_pz_r   <= s3_pz_r;
      s4_six_r  <= s3_six_r;
      s4_odd_r  <= s3_odd_r;
      s4_err_r  <= s3_err_r;
    end
    if (adv5) begin
      s5_r.err  <= s4_err_r;
      s5_r.six  <= s4_six_r;
      s5_r.odd  <= s4_odd_r;
      s5_r.base <= s4_six_r ? (cell_ext << 2) + (cell_ext << 1) : (cell_ext << 2) + cell_ext;
      for (int c = 0; c < 8; c++) begin
        s5_r.vtx[c] <= vtx_nxt[c];
      end
    end
  end

endmodule

// ----- rtl/tgcd_emitter.sv -----
// Holds one decoded cell; issues its tetrahedra one per cycle unless stalled,
// into a registered output stage. Uses tgcd_pkg for cell record and patterns.
module tgcd_emitter (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cell_valid,
  output logic                 cell_stall,
  input  tgcd_pkg::tgcd_cell_t cell_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tgcd_pkg::tgcd_out_t  out_data
);
  import tgcd_pkg::*;

  logic              hold_v_r;
  tgcd_cell_t        hold_r;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              out_v_r;
  tgcd_out_t         out_r, out_nxt;

  logic         out_free, fire, last, hold_ready;
  tet_corners_t pat;

  assign out_free   = !out_v_r || !out_stall;
  assign fire       = hold_v_r && out_free;
  assign last       = hold_r.err || (slot_r == (hold_r.six ? LAST_SLOT_SIX : LAST_SLOT_FIVE));
  assign hold_ready = !hold_v_r || (fire && last);
  assign cell_stall = !hold_ready;
  assign slot_nxt   = last ? '0 : slot_r + SLOT_W'(1);

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_comb begin
    pat = tet_pattern(hold_r.six, hold_r.odd, slot_r);
    out_nxt = '0;
    if (hold_r.err) begin
      out_nxt.cell_error = 1'b1;
      out_nxt.last_tet   = 1'b1;
    end else begin
      out_nxt.tet_index = hold_r.base + TET_W'(slot_r);
      out_nxt.corner_a  = hold_r.vtx[pat[0]];
      out_nxt.corner_b  = hold_r.vtx[pat[1]];
      out_nxt.corner_c  = hold_r.vtx[pat[2]];
      out_nxt.corner_d  = hold_r.vtx[pat[3]];
      out_nxt.last_tet  = last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      slot_r   <= '0;
      out_v_r  <= 1'b0;
    end else begin
      if (hold_ready) begin
        hold_v_r <= cell_valid;
      end
      if (fire) begin
        slot_r  <= slot_nxt;
        out_v_r <= 1'b1;
      end else if (out_free) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hold_ready && cell_valid) hold_r <= cell_data;
    if (fire) out_r <= out_nxt;
  end

endmodule

// ----- rtl/tet_grid_cell_decomposer_top.sv -----
// Tet grid cell decomposer: splits one grid cell (i,j,k) into five or six
// tetrahedra and issues one transaction per tetrahedron with its global index
// and four lattice vertex indices; a cell outside the grid gives a single
// error transaction. A cell passes a five-stage index pipeline, the cell hold
// register and the output register before its first result leaves. The
// output stage issues one result per cycle while out_stall is low: six per cell
// in six-tet style, five in five-tet style, one when out of range; it sets the
// sustained rate, and the index pipeline keeps up to five further cells behind
// it. The user must write grid size and style through the cfg port while no
// transaction is in flight; the block does not check it. Depends on tgcd_pkg.
module tet_grid_cell_decomposer_top #(
  parameter int MAX_CELLS_PER_AXIS = 1023
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [tgcd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tgcd_pkg::CELLS_W-1:0]     cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  tgcd_pkg::tgcd_in_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output tgcd_pkg::tgcd_out_t              out_data
);
  import tgcd_pkg::*;

  localparam logic [CELLS_W-1:0] CELLS_CLAMP =
    (MAX_CELLS_PER_AXIS >= int'(CELLS_FIELD_MAX)) ? CELLS_FIELD_MAX
                                                 : CELLS_W'(MAX_CELLS_PER_AXIS);

  logic [CELLS_W-1:0] cells_x_r, cells_y_r, cells_z_r;
  logic               split_style_r;
  tgcd_cfg_t          cfg;

  logic       cell_valid, cell_stall;
  tgcd_cell_t cell_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_x_r     <= CELLS_W'(1);
      cells_y_r     <= CELLS_W'(1);
      cells_z_r     <= CELLS_W'(1);
      split_style_r <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_CELLS_X:     cells_x_r     <= cfg_wdata;
        REG_CELLS_Y:     cells_y_r     <= cfg_wdata;
        REG_CELLS_Z:     cells_z_r     <= cfg_wdata;
        REG_SPLIT_STYLE: split_style_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.nx  = (cells_x_r > CELLS_CLAMP) ? CELLS_CLAMP : cells_x_r;
    cfg.ny  = (cells_y_r > CELLS_CLAMP) ? CELLS_CLAMP : cells_y_r;
    cfg.nz  = (cells_z_r > CELLS_CLAMP) ? CELLS_CLAMP : cells_z_r;
    cfg.six = split_style_r;
  end

  tgcd_index_pipe u_index_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .cell_valid (cell_valid),
    .cell_stall (cell_stall),
    .cell_data  (cell_data)
  );

  tgcd_emitter u_emitter (
    .clk        (clk),
    .rst_n      (rst_n),
    .cell_valid (cell_valid),
    .cell_stall (cell_stall),
    .cell_data  (cell_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ----- rtl/tgcd_checker.sv -----
// Port-level checks on the decomposer result channel, bound to the top level.
// Depends on tgcd_pkg and tet_grid_cell_decomposer_top_defines.svh.
`include "tet_grid_cell_decomposer_top_defines.svh"

module tgcd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input tgcd_pkg::tgcd_out_t out_data
);
  import tgcd_pkg::*;

  logic out_acc;
  assign out_acc = out_valid && !out_stall;

  `TGCD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

  `TGCD_ASSERT_IMPLY(a_err_last, clk, rst_n, out_valid && out_data.cell_error, out_data.last_tet)

  `TGCD_ASSERT_IMPLY(a_err_zero, clk, rst_n, out_valid && out_data.cell_error, out_data.tet_index == '0 && out_data.corner_a == '0 && out_data.corner_d == '0)

  `TGCD_ASSERT_IMPLY(a_tet_seq, clk, rst_n, $past(rst_n) && $past(out_acc) && !$past(out_data.last_tet), out_valid && out_data.tet_index == TET_W'($past(out_data.tet_index) + TET_W'(1)))

endmodule

bind tet_grid_cell_decomposer_top tgcd_checker u_tgcd_checker (.*);

// ----- tb/sv/tet_grid_cell_decomposer_top_tb.sv -----
// Self-checking testbench for tet_grid_cell_decomposer_top: directed cells, then random phases.
// Predicts each cell's tetrahedra in the bench and checks every output transaction in order.
// Depends on tgcd_pkg and the tet_grid_cell_decomposer_top RTL.
module tet_grid_cell_decomposer_top_tb;
  import tgcd_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int NUM_PHASES      = 8;
  localparam int CELLS_PER_PHASE = 19;

  typedef enum logic [1:0] {CHK_PREDICT, CHK_RESET_CELL, CHK_OUT_OF_GRID} chk_e;

  typedef struct packed {
    logic               regrid;
    logic [CELLS_W-1:0] nx;
    logic [CELLS_W-1:0] ny;
    logic [CELLS_W-1:0] nz;
    logic               six;
    tgcd_in_t           pos;
    chk_e               chk;
  } step_row_t;

  localparam int NUM_ROWS = 22;
  localparam step_row_t STEP_ROWS [NUM_ROWS] = '{
    '{1'b0, 10'd1, 10'd1, 10'd1, 1'b0, '{10'd0, 10'd0, 10'd0}, CHK_RESET_CELL},
    '{1'b0, 10'd1, 10'd1, 10'd1, 1'b0, '{10'd1, 10'd0, 10'd0}, CHK_OUT_OF_GRID},
    '{1'b0, 10'd1, 10'd1, 10'd1, 1'b0, '{10'd0, 10'd1, 10'd0}, CHK_OUT_OF_GRID},
    '{1'b0, 10'd1, 10'd1, 10'd1, 1'b0, '{10'd0, 10'd0, 10'd1}, CHK_OUT_OF_GRID},
    '{1'b0, 10'd1, 10'd1, 10'd1, 1'b0, '{10'd1023, 10'd1023, 10'd1023}, CHK_OUT_OF_GRID},
    '{1'b1, 10'd1023, 10'd1023, 10'd1023, 1'b1, '{10'd1022, 10'd1022, 10'd1022}, CHK_PREDICT},
    '{1'b0, 10'd1023, 10'd1023, 10'd1023, 1'b1, '{10'd0, 10'd0, 10'd0}, CHK_PREDICT},
    '{1'b0, 10'd1023, 10'd1023, 10'd1023, 1'b1, '{10'd1023, 10'd0, 10'd0}, CHK_OUT_OF_GRID},
    '{1'b0, 10'd1023, 10'd1023, 10'd1023, 1'b1, '{10'd0, 10'd1023, 10'd0}, CHK_OUT_OF_GRID},
    '{1'b0, 10'd1023, 10'd1023, 10'd1023, 1'b1, '{10'd0, 10'd0, 10'd1023}, CHK_OUT_OF_GRID},
    '{1'b0, 10'd1023, 10'd1023, 10'd1023, 1'b1, '{10'd511, 10'd512, 10'd341}, CHK_PREDICT},
    '{1'b1, 10'd1023, 10'd1023, 10'd1023, 1'b0, '{10'd1022, 10'd1022, 10'd1022}, CHK_PREDICT},
    '{1'b0, 10'd1023, 10'd1023, 10'd1023, 1'b0, '{10'd1022, 10'd1022, 10'd1021}, CHK_PREDICT},
    '{1'b0, 10'd1023, 10'd1023, 10'd1023, 1'b0, '{10'd1, 10'd0, 10'd0}, CHK_PREDICT},
    '{1'b0, 10'd1023, 10'd1023, 10'd1023, 1'b0, '{10'd0, 10'd0, 10'd0}, CHK_PREDICT},
    '{1'b1, 10'd0, 10'd7, 10'd7, 1'b0, '{10'd0, 10'd0, 10'd0}, CHK_OUT_OF_GRID},
    '{1'b1, 10'd7, 10'd0, 10'd7, 1'b1, '{10'd3, 10'd0, 10'd3}, CHK_OUT_OF_GRID},
    '{1'b1, 10'd7, 10'd7, 10'd0, 1'b0, '{10'd0, 10'd0, 10'd0}, CHK_OUT_OF_GRID},
    '{1'b1, 10'd3, 10'd4, 10'd5, 1'b1, '{10'd2, 10'd3, 10'd4}, CHK_PREDICT},
    '{1'b0, 10'd3, 10'd4, 10'd5, 1'b1, '{10'd2, 10'd3, 10'd5}, CHK_OUT_OF_GRID},
    '{1'b0, 10'd3, 10'd4, 10'd5, 1'b1, '{10'd2, 10'd4, 10'd4}, CHK_OUT_OF_GRID},
    '{1'b0, 10'd3, 10'd4, 10'd5, 1'b1, '{10'd3, 10'd3, 10'd4}, CHK_OUT_OF_GRID}
  };

  // Corner offsets {dx, dy, dz} and tet splits, one octal digit per corner.
  localparam logic [2:0] CORNER_OFS [8] = '{
    3'b000, 3'b100, 3'b110, 3'b010, 3'b001, 3'b101, 3'b111, 3'b011};
  localparam logic [11:0] FIVE_EVEN_SPLIT [5] = '{
    12'o4613, 12'o6347, 12'o1304, 12'o3126, 12'o4165};
  localparam logic [11:0] FIVE_ODD_SPLIT [5] = '{
    12'o7025, 12'o2307, 12'o5704, 12'o7265, 12'o0125};
  localparam logic [11:0] SIX_SPLIT [6] = '{
    12'o0467, 12'o6054, 12'o1056, 12'o1206, 12'o0623, 12'o6307};

  // Lattice indices of the single cell of the reset grid, one hex digit per corner.
  localparam logic [15:0] RESET_CELL_TETS [5] = '{
    16'h1742, 16'h7213, 16'h4201, 16'h2467, 16'h1475};

  localparam tgcd_out_t OUT_OF_GRID = '{
    tet_index: '0, corner_a: '0, corner_b: '0, corner_c: '0, corner_d: '0,
    cell_error: 1'b1, last_tet: 1'b1};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_CELLS_X;
  logic [CELLS_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  tgcd_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tgcd_out_t out_data;

  logic [CELLS_W-1:0] grid_x = 10'd1;
  logic [CELLS_W-1:0] grid_y = 10'd1;
  logic [CELLS_W-1:0] grid_z = 10'd1;
  logic grid_six = 1'b0;

  tgcd_out_t tets_due [$];
  tgcd_out_t want_tet;
  int fail_cnt = 0;
  int cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_off_reqs = 0;
  int hold_off_seen = 0;
  int hold_left = 0;

  tet_grid_cell_decomposer_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tet_grid_cell_decomposer_top_tb NOT OK");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_off_reqs != hold_off_seen) begin
      hold_off_seen <= hold_off_reqs;
      hold_left <= HOLD_OFF_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [TET_W-1:0] want,
                             input logic [TET_W-1:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (tets_due.size() == 0) begin
        $error("unexpected transaction, tet_index %0d", out_data.tet_index);
        fail_cnt++;
      end else begin
        want_tet = tets_due.pop_front();
        check_field("tet_index", want_tet.tet_index, out_data.tet_index);
        check_field("corner_a", TET_W'(want_tet.corner_a), TET_W'(out_data.corner_a));
        check_field("corner_b", TET_W'(want_tet.corner_b), TET_W'(out_data.corner_b));
        check_field("corner_c", TET_W'(want_tet.corner_c), TET_W'(out_data.corner_c));
        check_field("corner_d", TET_W'(want_tet.corner_d), TET_W'(out_data.corner_d));
        check_field("cell_error", TET_W'(want_tet.cell_error), TET_W'(out_data.cell_error));
        check_field("last_tet", TET_W'(want_tet.last_tet), TET_W'(out_data.last_tet));
      end
    end
  end

  task automatic queue_tet(input tgcd_out_t t);
    tets_due.insert(tets_due.size(), t);
  endtask

  task automatic predict_tets(input tgcd_in_t c_pos);
    logic [63:0] ci, cj, ck, py, pz, base;
    logic [11:0] pat;
    logic [2:0] ofs;
    logic [VTX_W-1:0] vtx [4];
    int count;
    tgcd_out_t t;
    ci = 64'(c_pos.cell_i);
    cj = 64'(c_pos.cell_j);
    ck = 64'(c_pos.cell_k);
    if (ci >= grid_x || cj >= grid_y || ck >= grid_z) begin
      queue_tet(OUT_OF_GRID);
      return;
    end
    count = grid_six ? 6 : 5;
    py = 64'(grid_y) + 1;
    pz = 64'(grid_z) + 1;
    base = ((ci * grid_y + cj) * grid_z + ck) * count;
    for (int s = 0; s < count; s++) begin
      if (grid_six) pat = SIX_SPLIT[s];
      else if ((ci + cj + ck) % 2 == 0) pat = FIVE_EVEN_SPLIT[s];
      else pat = FIVE_ODD_SPLIT[s];
      for (int f = 0; f < 4; f++) begin
        ofs = CORNER_OFS[pat[11-3*f -: 3]];
        vtx[f] = VTX_W'(((ci + ofs[2]) * py + cj + ofs[1]) * pz + ck + ofs[0]);
      end
      t.tet_index = TET_W'(base + s);
      t.corner_a = vtx[0];
      t.corner_b = vtx[1];
      t.corner_c = vtx[2];
      t.corner_d = vtx[3];
      t.cell_error = 1'b0;
      t.last_tet = (s == count - 1);
      queue_tet(t);
    end
  endtask

  task automatic send_cell(input tgcd_in_t c_pos, input chk_e chk);
    tgcd_out_t t;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= c_pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (chk)
      CHK_OUT_OF_GRID: queue_tet(OUT_OF_GRID);
      CHK_RESET_CELL: begin
        for (int s = 0; s < 5; s++) begin
          t.tet_index = TET_W'(s);
          t.corner_a = VTX_W'(RESET_CELL_TETS[s][15:12]);
          t.corner_b = VTX_W'(RESET_CELL_TETS[s][11:8]);
          t.corner_c = VTX_W'(RESET_CELL_TETS[s][7:4]);
          t.corner_d = VTX_W'(RESET_CELL_TETS[s][3:0]);
          t.cell_error = 1'b0;
          t.last_tet = (s == 4);
          queue_tet(t);
        end
      end
      default: predict_tets(c_pos);
    endcase
  endtask

  task automatic drain_tets;
    @(negedge clk);
    in_valid <= 1'b0;
    while (tets_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_grid(input logic [CELLS_W-1:0] nx, input logic [CELLS_W-1:0] ny,
                          input logic [CELLS_W-1:0] nz, input logic six);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_CELLS_X;
    cfg_wdata <= nx;
    @(negedge clk);
    cfg_index <= REG_CELLS_Y;
    cfg_wdata <= ny;
    @(negedge clk);
    cfg_index <= REG_CELLS_Z;
    cfg_wdata <= nz;
    @(negedge clk);
    cfg_index <= REG_SPLIT_STYLE;
    cfg_wdata <= CELLS_W'(six);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    grid_x = nx;
    grid_y = ny;
    grid_z = nz;
    grid_six = six;
  endtask

  function automatic logic [CELLS_W-1:0] rand_coord(input logic [CELLS_W-1:0] n);
    if (n == 0 || $urandom_range(99) < 15) return CELLS_W'($urandom_range(1023));
    return CELLS_W'($urandom_range(n - 1));
  endfunction

  initial begin
    tgcd_in_t pos;
    logic [CELLS_W-1:0] nx, ny, nz;
    logic six;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < NUM_ROWS; r++) begin
      if (STEP_ROWS[r].regrid) begin
        drain_tets();
        set_grid(STEP_ROWS[r].nx, STEP_ROWS[r].ny, STEP_ROWS[r].nz, STEP_ROWS[r].six);
      end
      send_cell(STEP_ROWS[r].pos, STEP_ROWS[r].chk);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_tets();
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 64; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 64; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      six = 1'($urandom_range(1));
      case (ph)
        0: begin nx = 10'd1023; ny = 10'd1023; nz = 10'd1023; six = 1'b1; end
        1, 4: begin
          nx = CELLS_W'($urandom_range(1, 8));
          ny = CELLS_W'($urandom_range(1, 8));
          nz = CELLS_W'($urandom_range(1, 8));
        end
        3: begin nx = 10'd1; ny = 10'd1; nz = 10'd1; end
        5: begin nx = 10'd1023; ny = 10'd1023; nz = 10'd1023; six = 1'b0; end
        7: begin
          nx = CELLS_W'($urandom_range(0, 4));
          ny = CELLS_W'($urandom_range(0, 4));
          nz = CELLS_W'($urandom_range(0, 4));
        end
        default: begin
          nx = CELLS_W'($urandom_range(1, 1023));
          ny = CELLS_W'($urandom_range(1, 1023));
          nz = CELLS_W'($urandom_range(1, 1023));
        end
      endcase
      set_grid(nx, ny, nz, six);
      if (ph == 0) hold_off_reqs++;
      for (int n = 0; n < CELLS_PER_PHASE; n++) begin
        pos.cell_i = rand_coord(grid_x);
        pos.cell_j = rand_coord(grid_y);
        pos.cell_k = rand_coord(grid_z);
        send_cell(pos, CHK_PREDICT);
      end
    end

    drain_tets();
    repeat (20) @(posedge clk);
    if (fail_cnt == 0 && tets_due.size() == 0) begin
      $display("tet_grid_cell_decomposer_top_tb OK");
    end else begin
      $display("tet_grid_cell_decomposer_top_tb NOT OK");
    end
    $finish;
  end

endmodule
